// ----- sv/ftab_pkg.sv -----
// ----------------------------------------------------------------------------
// ftab_pkg
// Types and constants shared by the forwarding table engine modules.
// ----------------------------------------------------------------------------
package ftab_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int NODE_W      = 7;
    localparam int OP_W        = 2;
    localparam int STAT_W      = 3;
    localparam int OUT_CNT_W   = 7;
    localparam int QUEUE_DEPTH = 2;

    // Decoded operation carried from front to back
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_DONE      = 3'd3,
        ST_MISS      = 3'd4
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [NODE_W-1:0] key_node;
        logic [NODE_W-1:0] neighbor_node;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [NODE_W-1:0]    found_neighbor;
        logic [OUT_CNT_W-1:0] removed_count;
        logic [OUT_CNT_W-1:0] entry_count;
    } t_rsp;

    typedef struct packed {
        t_op               op;
        logic [NODE_W-1:0] key;
        logic [NODE_W-1:0] nbr;
    } t_cmd;

    // Queue to engine handshake
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_if;

    function automatic logic [OUT_CNT_W-1:0] to_out_cnt(input logic [CNT_W-1:0] c);
        return OUT_CNT_W'(c);
    endfunction

endpackage

// ----- sv/ftab_front.sv -----
// ----------------------------------------------------------------------------
// ftab_front
// Accepts requests, decodes the operation and queues them for the engine.
// ----------------------------------------------------------------------------
module ftab_front import ftab_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_req    i_req,
    output logic    o_busy,
    output t_cmd_if o_cmd,
    input  logic    i_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd               r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [QCNT_W-1:0]  r_cnt,  n_cnt;
    logic               push;
    logic               pop;
    t_cmd               dec;

    always_comb begin
        unique case (i_req.operation)
            OP_INSERT: dec.op = OP_INSERT;
            OP_REMOVE: dec.op = OP_REMOVE;
            OP_LOOKUP: dec.op = OP_LOOKUP;
            default:   dec.op = OP_NOP;
        endcase
        dec.key = i_req.key_node;
        dec.nbr = i_req.neighbor_node;
    end

    assign o_busy = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign push   = i_start && !o_busy;
    assign pop    = i_pop && (r_cnt != '0);

    assign o_cmd.valid = (r_cnt != '0);
    assign o_cmd.cmd   = r_q[r_rptr];

    always_comb begin
        n_wptr = push ? PTR_W'((32'(r_wptr) + 1) % QUEUE_DEPTH) : r_wptr;
        n_rptr = pop  ? PTR_W'((32'(r_rptr) + 1) % QUEUE_DEPTH) : r_rptr;
        n_cnt  = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= dec;
        end
    end

endmodule

// ----- sv/ftab_back.sv -----
// ----------------------------------------------------------------------------
// ftab_back
// Table engine: scans the entry memory at most once per command, compacts on remove,
// appends on insert and registers the single response.
// ----------------------------------------------------------------------------
module ftab_back import ftab_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd_if i_cmd,
    output logic    o_pop,
    output logic    o_valid,
    output t_rsp    o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    typedef struct packed {
        logic [NODE_W-1:0] dst;
        logic [NODE_W-1:0] nbr;
    } t_entry;

    t_entry             mem [TABLE_DEPTH];
    t_entry             r_rdata;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    t_entry             mem_wdata;

    t_state             r_state,   n_state;
    t_cmd               r_cmd,     n_cmd;
    logic [CNT_W-1:0]   r_used,    n_used;
    logic [CNT_W-1:0]   r_issue,   n_issue;
    logic [CNT_W-1:0]   r_wr,      n_wr;
    logic [CNT_W-1:0]   r_removed, n_removed;
    logic               r_dv,      n_dv;
    logic               r_valid,   n_valid;
    t_rsp               r_rsp,     n_rsp;
    logic               issue;

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_used    = r_used;
        n_issue   = r_issue;
        n_wr      = r_wr;
        n_removed = r_removed;
        n_dv      = 1'b0;
        n_valid   = 1'b0;
        n_rsp     = r_rsp;
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_wr[ADDR_W-1:0];
        mem_wdata = r_rdata;
        rd_addr   = r_issue[ADDR_W-1:0];
        issue     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    o_pop     = 1'b1;
                    n_cmd     = i_cmd.cmd;
                    n_issue   = '0;
                    n_wr      = '0;
                    n_removed = '0;
                    n_state   = (i_cmd.cmd.op == OP_NOP) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                // one read issued per cycle, data evaluated in the following cycle
                issue = (r_issue < r_used);
                n_dv  = issue;
                if (issue) begin
                    n_issue = r_issue + 1'b1;
                end
                if (r_dv) begin
                    case (r_cmd.op)
                        OP_INSERT: begin
                            if (r_rdata.dst == r_cmd.key && r_rdata.nbr == r_cmd.nbr) begin
                                n_valid = 1'b1;
                                n_rsp   = '{status: ST_DUPLICATE, found_neighbor: '0,
                                            removed_count: '0,
                                            entry_count: to_out_cnt(r_used)};
                                n_dv    = 1'b0;
                                n_state = S_IDLE;
                            end
                        end
                        OP_LOOKUP: begin
                            if (r_rdata.dst == r_cmd.key) begin
                                n_valid = 1'b1;
                                n_rsp   = '{status: ST_DONE, found_neighbor: r_rdata.nbr,
                                            removed_count: '0,
                                            entry_count: to_out_cnt(r_used)};
                                n_dv    = 1'b0;
                                n_state = S_IDLE;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_rdata.dst == r_cmd.key || r_rdata.nbr == r_cmd.key) begin
                                n_removed = r_removed + 1'b1;
                            end else begin
                                // compact: write position never passes read position
                                mem_we = 1'b1;
                                n_wr   = r_wr + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end else if (!issue) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                n_rsp   = '{status: ST_DONE, found_neighbor: '0, removed_count: '0,
                            entry_count: to_out_cnt(r_used)};
                case (r_cmd.op)
                    OP_INSERT: begin
                        if (r_used == CNT_W'(TABLE_DEPTH)) begin
                            n_rsp.status = ST_FULL;
                        end else begin
                            mem_we            = 1'b1;
                            mem_waddr         = r_used[ADDR_W-1:0];
                            mem_wdata         = '{dst: r_cmd.key, nbr: r_cmd.nbr};
                            n_used            = r_used + 1'b1;
                            n_rsp.status      = ST_INSERTED;
                            n_rsp.entry_count = to_out_cnt(r_used + 1'b1);
                        end
                    end
                    OP_REMOVE: begin
                        n_used              = r_wr;
                        n_rsp.removed_count = to_out_cnt(r_removed);
                        n_rsp.entry_count   = to_out_cnt(r_wr);
                    end
                    OP_LOOKUP: begin
                        n_rsp.status = ST_MISS;
                    end
                    default: ;
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_dv    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_dv    <= n_dv;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_issue   <= n_issue;
        r_wr      <= n_wr;
        r_removed <= n_removed;
        r_rsp     <= n_rsp;
    end

    // Entry memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[rd_addr];
    end

endmodule

// ----- sv/forwarding_table_engine.sv -----
// ----------------------------------------------------------------------------
// forwarding_table_engine
// Ordered (destination, neighbor) forwarding table with insert, remove and
// lookup commands, one response per command.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge where i_start is high and o_busy is low.
// Every request yields exactly one response, shown on o_rsp for a single cycle
// with o_valid high; the receiver cannot stall it, so it must capture it then.
// A command passes in order through the queue, the pop into the engine, a scan
// that reads one entry from the table memory per cycle through its single
// registered read port, a drain of the last read, the finish step and the
// output register. With an empty table the scan reads nothing. A lookup hit or
// a duplicate insert stops the scan early and answers without the finish step;
// the unused operation code skips the scan.
// Commands are handled one at a time; a two-entry queue lets up to two
// further requests wait, and o_busy rises only when that queue is full.
// The table is empty after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module forwarding_table_engine import ftab_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_valid,
    output t_rsp o_rsp
);

    // front to back command channel
    t_cmd_if cmd_if;
    logic    cmd_pop;

    // Front: decode and queue requests
    ftab_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_cmd   (cmd_if),
        .i_pop   (cmd_pop)
    );

    // Back: scan, compact and append over the entry memory
    ftab_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_pop   (cmd_pop),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule
